// ----- rtl/core/hist_pkg.sv -----
// ----------------------------------------------------------------------------
// hist_pkg
// shared types and constants for the hashed id slot table
// ----------------------------------------------------------------------------
package hist_pkg;

    localparam int DEF_SLOTS    = 1024;
    localparam int DEF_ID_WIDTH = 32;
    localparam int TID_W        = 32;
    localparam int FUNC_W       = 2;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_REL    = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_CHK,
        ST_APROBE,
        ST_ACHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [TID_W-1:0] dividend;
    } mod_req_t;

endpackage

// ----- rtl/core/hist_ram.sv -----
// ----------------------------------------------------------------------------
// hist_ram
// slot memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module hist_ram import hist_pkg::*; #(
    parameter int DEPTH  = DEF_SLOTS,
    parameter int DATA_W = DEF_ID_WIDTH + 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/hist_mod.sv -----
// ----------------------------------------------------------------------------
// hist_mod
// remainder unit, reciprocal multiply for the quotient, then multiply back
// and subtract, one step a cycle
// ----------------------------------------------------------------------------
module hist_mod import hist_pkg::*; #(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mod_req_t                 req,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] rem
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SHIFT  = TID_W + SLOT_W;
    localparam int PROD_W = 2 * TID_W + 1;
    localparam logic [TID_W:0] RECIP =
        (TID_W+1)'(((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
    localparam logic [TID_W-1:0] DIVISOR = TID_W'(SLOTS);

    logic              st1_reg, st1_next;
    logic              st2_reg, st2_next;
    logic              done_reg, done_next;
    logic [TID_W-1:0]  dv_reg, dv_next;
    logic [TID_W-1:0]  q_reg, q_next;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] prod;
    logic [TID_W-1:0]  back;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg  <= 1'b0;
            st2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            st1_reg  <= st1_next;
            st2_reg  <= st2_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dv_reg  <= dv_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        prod      = PROD_W'(dv_reg) * PROD_W'(RECIP);
        back      = q_reg * DIVISOR;
        st1_next  = req.start;
        st2_next  = st1_reg;
        done_next = st2_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            dv_next = req.dividend;
        end
        if (st1_reg) begin
            q_next = TID_W'(prod >> SHIFT);
        end
        if (st2_reg) begin
            rem_next = SLOT_W'(dv_reg - back);
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/core/hashed_id_slot_table_unit.sv -----
// ----------------------------------------------------------------------------
// hashed_id_slot_table_unit
// slot table handing out nonzero ids, each kept in slot id mod SLOTS
// ----------------------------------------------------------------------------
// After reset the unit sweeps the slot memory, one slot a cycle, and takes no
// request until the sweep ends. One request is worked at a time through a
// single-port read of the slot memory. Allocate reads and checks one probed
// slot after another, starting at the counter's slot, until it finds a free
// slot or has probed all SLOTS slots. Release and lookup read one slot, taken
// from the low bits of the id when SLOTS is a power of two; otherwise the slot
// index comes from a reciprocal multiplication in hist_mod. Func 3 replies
// with a zero id and ok low. A new request is taken while a finished result
// still waits on the master side.
module hashed_id_slot_table_unit import hist_pkg::*; #(
    parameter int SLOTS    = DEF_SLOTS,
    parameter int ID_WIDTH = DEF_ID_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // func[1:0], tid[33:2], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // result_id[31:0], ok[32], zero pad
);

    localparam int  SLOT_W   = $clog2(SLOTS);
    localparam int  CMP_W    = (ID_WIDTH > TID_W) ? ID_WIDTH : TID_W;
    localparam int  RAM_W    = ID_WIDTH + 1;
    localparam bit  IS_POW2  = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [TID_W-1:0]   tid_reg, tid_next;
    logic [ID_WIDTH-1:0] nid_reg, nid_next;
    logic [SLOT_W-1:0]  nslot_reg, nslot_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [TID_W-1:0]   res_id_reg, res_id_next;
    logic               res_ok_reg, res_ok_next;
    logic               out_valid_reg, out_valid_next;
    logic [TID_W-1:0]   out_id_reg, out_id_next;
    logic               out_ok_reg, out_ok_next;

    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [RAM_W-1:0]   wdata;
    logic               re;
    logic [SLOT_W-1:0]  raddr;
    logic [RAM_W-1:0]   rdata;
    mod_req_t           mod_req;
    logic               mod_done;
    logic [SLOT_W-1:0]  mod_rem;

    logic [ID_WIDTH-1:0] nid_inc;
    logic [ID_WIDTH-1:0] nid_adv;
    logic [SLOT_W-1:0]   nslot_adv;
    logic                hit;
    logic                out_free;

    hist_ram #(
        .DEPTH  (SLOTS),
        .DATA_W (RAM_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    hist_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            nid_reg       <= ID_WIDTH'(1);
            nslot_reg     <= SLOT_W'(1);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            nid_reg       <= nid_next;
            nslot_reg     <= nslot_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        tid_reg    <= tid_next;
        slot_reg   <= slot_next;
        res_id_reg <= res_id_next;
        res_ok_reg <= res_ok_next;
        out_id_reg <= out_id_next;
        out_ok_reg <= out_ok_next;
    end

    // counter advance, skipping zero on wrap, slot index tracked alongside
    always_comb begin
        nid_inc = nid_reg + 1'b1;
        if (nid_inc == '0) begin
            nid_adv   = ID_WIDTH'(1);
            nslot_adv = SLOT_W'(1);
        end else begin
            nid_adv   = nid_inc;
            nslot_adv = (nslot_reg == SLOT_LAST) ? '0 : nslot_reg + 1'b1;
        end
    end

    assign hit = (tid_reg != '0) && rdata[ID_WIDTH]
              && (CMP_W'(rdata[ID_WIDTH-1:0]) == CMP_W'(tid_reg));
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        tid_next       = tid_reg;
        nid_next       = nid_reg;
        nslot_next     = nslot_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        res_id_next    = res_id_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_ok_next    = out_ok_reg;
        we             = 1'b0;
        waddr          = slot_reg;
        wdata          = '0;
        re             = 1'b0;
        raddr          = slot_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = tid_reg;
        s_tready       = 1'b0;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = '0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_LAST) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    func_next = func_t'(s_tdata[FUNC_W-1:0]);
                    tid_next  = s_tdata[FUNC_W +: TID_W];
                    mod_req.dividend = s_tdata[FUNC_W +: TID_W];
                    unique case (func_t'(s_tdata[FUNC_W-1:0]))
                        FUNC_ALLOC: begin
                            idx_next   = '0;
                            state_next = ST_APROBE;
                        end
                        FUNC_REL, FUNC_LOOKUP: begin
                            if (IS_POW2) begin
                                slot_next  = SLOT_W'(s_tdata[FUNC_W +: TID_W]);
                                state_next = ST_RD;
                            end else begin
                                mod_req.start = 1'b1;
                                state_next    = ST_MOD;
                            end
                        end
                        default: begin
                            res_id_next = '0;
                            res_ok_next = 1'b0;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    slot_next  = mod_rem;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                re         = 1'b1;
                raddr      = slot_reg;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                res_id_next = '0;
                res_ok_next = hit;
                if (hit) begin
                    if (func_reg == FUNC_REL) begin
                        we    = 1'b1;
                        waddr = slot_reg;
                        wdata = '0;
                    end else begin
                        res_id_next = tid_reg;
                    end
                end
                state_next = ST_DONE;
            end
            ST_APROBE: begin
                re         = 1'b1;
                raddr      = nslot_reg;
                state_next = ST_ACHK;
            end
            ST_ACHK: begin
                nid_next   = nid_adv;
                nslot_next = nslot_adv;
                if (!rdata[ID_WIDTH]) begin
                    we          = 1'b1;
                    waddr       = nslot_reg;
                    wdata       = {1'b1, nid_reg};
                    res_id_next = TID_W'(nid_reg);
                    res_ok_next = 1'b1;
                    state_next  = ST_DONE;
                end else if (idx_reg == SLOT_LAST) begin
                    res_id_next = '0;
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_APROBE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - TID_W - 1)'(0), out_ok_reg, out_id_reg};

endmodule

// ----- tb/sv/hashed_id_slot_table_checker.sv -----
// ----------------------------------------------------------------------------
// hashed_id_slot_table_checker
// watches both streams of the slot table, predicts every reply from its own
// copy of the slot table and id counter, and compares each reply in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hashed_id_slot_table_checker import hist_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // func[1:0], tid[33:2], zero pad
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // result_id[31:0], ok[32], zero pad
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [TID_W-1:0] id;
        logic             ok;
    } table_reply_t;

    logic                    slot_used  [DEF_SLOTS];
    logic [DEF_ID_WIDTH-1:0] slot_owner [DEF_SLOTS];
    logic [DEF_ID_WIDTH-1:0] id_counter;
    table_reply_t            expected_replies [$];

    // counter never lands on zero
    function automatic logic [DEF_ID_WIDTH-1:0] bump_id(input logic [DEF_ID_WIDTH-1:0] v);
        logic [DEF_ID_WIDTH-1:0] n;
        n = v + 1'b1;
        return (n == '0) ? DEF_ID_WIDTH'(1) : n;
    endfunction

    function automatic table_reply_t serve_request(input func_t f, input logic [TID_W-1:0] tid);
        table_reply_t r;
        int unsigned  s;
        logic         hit;
        r = '0;
        case (f)
            FUNC_ALLOC: begin
                for (int k = 0; k < DEF_SLOTS; k++) begin
                    s = id_counter % DEF_SLOTS;
                    if (!slot_used[s]) begin
                        slot_used[s]  = 1'b1;
                        slot_owner[s] = id_counter;
                        r.id          = id_counter;
                        r.ok          = 1'b1;
                        id_counter    = bump_id(id_counter);
                        return r;
                    end
                    id_counter = bump_id(id_counter);
                end
            end
            FUNC_REL, FUNC_LOOKUP: begin
                s   = tid % DEF_SLOTS;
                hit = (tid != '0) && slot_used[s] && (slot_owner[s] == tid);
                if (hit) begin
                    r.ok = 1'b1;
                    if (f == FUNC_REL) begin
                        slot_used[s] = 1'b0;
                    end else begin
                        r.id = tid;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        table_reply_t got;
        table_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < DEF_SLOTS; i++) slot_used[i] = 1'b0;
            id_counter = DEF_ID_WIDTH'(1);
            expected_replies.delete();
        end else begin
            // a reply never belongs to the request taken on the same edge
            if (m_tvalid && m_tready) begin
                got.id = m_tdata[TID_W-1:0];
                got.ok = m_tdata[TID_W];
                if (expected_replies.size() == 0) begin
                    fail_count++;
                    $display("%0t: reply with none expected, actual id %h ok %b",
                             $time, got.id, got.ok);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.id !== want.id) begin
                        fail_count++;
                        $display("%0t: result_id expected %h actual %h", $time, want.id, got.id);
                    end
                    if (got.ok !== want.ok) begin
                        fail_count++;
                        $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(serve_request(func_t'(s_tdata[FUNC_W-1:0]),
                                                         s_tdata[FUNC_W +: TID_W]));
            end
        end
        pending = expected_replies.size();
    end

endmodule

// ----- tb/sv/hashed_id_slot_table_unit_tb.sv -----
// ----------------------------------------------------------------------------
// hashed_id_slot_table_unit_tb
// drives allocate, release, lookup and func 3 requests into the slot table:
// a short directed set, a run that fills the table past full, then a mixed
// run of all four kinds; replies are checked by the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hashed_id_slot_table_unit_tb import hist_pkg::*;;

    // worst case: ~1200 requests each probing a full table with both sides
    // stalled, plus the clearing sweep, taken several times over
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int FILL_ALLOCS = DEF_SLOTS + 6;
    localparam int MIXED_COUNT = 80;
    localparam int CALM_COUNT  = 40;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int                   fail_count;
    int                   pending;
    int                   cycles = 0;
    int                   stall_left = 0;
    logic                 rx_calm = 1'b0;
    logic                 quiet = 1'b0;
    logic [TID_W-1:0]     live_ids [$];

    hashed_id_slot_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hashed_id_slot_table_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls in bursts, with calm stretches between
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else begin
            if ($urandom_range(0, 299) == 0) rx_calm <= ~rx_calm;
            if (stall_left > 1) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (stall_left == 1) begin
                m_tready   <= 1'b1;
                stall_left <= 0;
            end else if (!quiet && !rx_calm && $urandom_range(0, 7) == 0) begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(1, 19);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ids seen in successful replies, used to aim releases and lookups
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tdata[TID_W] && m_tdata[TID_W-1:0] != '0)
            live_ids.push_back(m_tdata[TID_W-1:0]);
    end

    task automatic send_request(input func_t f, input logic [TID_W-1:0] tid);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-FUNC_W-TID_W){1'b0}}, tid, f};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [TID_W-1:0] pick_live(input logic take);
        int unsigned      idx;
        logic [TID_W-1:0] id;
        if (live_ids.size() == 0) return $urandom;
        idx = $urandom_range(0, live_ids.size() - 1);
        id  = live_ids[idx];
        if (take) live_ids.delete(idx);
        return id;
    endfunction

    initial begin
        int unsigned      pick;
        int               allocs;
        logic [TID_W-1:0] id;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        send_request(FUNC_ALLOC,  32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h0000_0001);
        send_request(FUNC_LOOKUP, 32'h0000_0401);
        send_request(FUNC_REL,    32'h0000_0401);
        send_request(FUNC_REL,    32'h0000_0001);
        send_request(FUNC_REL,    32'h0000_0001);
        send_request(FUNC_LOOKUP, 32'h0000_0001);
        send_request(FUNC_ALLOC,  32'hFFFF_FFFF);
        send_request(FUNC_ALLOC,  32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h0000_0000);
        send_request(FUNC_REL,    32'h0000_0000);
        send_request(FUNC_NONE,   32'hFFFF_FFFF);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFF);
        send_request(FUNC_LOOKUP, 32'hFFFF_FC02);
        send_request(FUNC_LOOKUP, 32'h0000_0002);
        send_request(FUNC_REL,    32'h0000_0003);
        send_request(FUNC_ALLOC,  32'h5555_5555);
        send_request(FUNC_LOOKUP, 32'h8000_0000);
        send_request(FUNC_REL,    32'hFFFF_FFFF);
        send_request(FUNC_NONE,   32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h0000_0004);

        // fill the table and run past full
        allocs = 0;
        while (allocs < FILL_ALLOCS) begin
            if ($urandom_range(0, 99) < 3) begin
                send_request(FUNC_LOOKUP, pick_live(1'b0));
            end else begin
                send_request(FUNC_ALLOC, $urandom);
                allocs++;
            end
        end

        // mixed traffic on a nearly full table
        for (int n = 0; n < MIXED_COUNT; n++) begin
            if (n == MIXED_COUNT - CALM_COUNT) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_request(FUNC_ALLOC, $urandom);
            end else if (pick < 55) begin
                send_request(FUNC_REL, pick_live(1'b1));
            end else if (pick < 75) begin
                send_request(FUNC_LOOKUP, pick_live(1'b0));
            end else if (pick < 85) begin
                send_request(func_t'($urandom_range(1, 2)), $urandom);
            end else if (pick < 90) begin
                send_request(func_t'($urandom_range(1, 2)), '0);
            end else if (pick < 95) begin
                send_request(FUNC_NONE, $urandom);
            end else begin
                // same slot, different id
                id = pick_live(1'b0) ^ ($urandom_range(1, 1023) << 10);
                send_request(func_t'($urandom_range(1, 2)), id);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- hashed_id_slot_table_unit.f -----
rtl/core/hist_pkg.sv
rtl/core/hist_ram.sv
rtl/core/hist_mod.sv
rtl/core/hashed_id_slot_table_unit.sv
tb/sv/hashed_id_slot_table_checker.sv
tb/sv/hashed_id_slot_table_unit_tb.sv
